[hdl/isqrt_pkg.sv]
// Package for the integer square root pipeline: widths and the per-stage item type.
`default_nettype none
package isqrt_pkg;

  localparam int unsigned RADICAND_WIDTH = 64;
  localparam int unsigned ROOT_WIDTH     = (RADICAND_WIDTH + 1) / 2;
  localparam int unsigned PAD_WIDTH      = 2 * ROOT_WIDTH;
  localparam int unsigned REM_WIDTH      = ROOT_WIDTH + 1;
  localparam int unsigned EXT_WIDTH      = REM_WIDTH + 2;

  typedef struct packed {
    logic [PAD_WIDTH-1:0]  rad;
    logic [REM_WIDTH-1:0]  rem;
    logic [ROOT_WIDTH-1:0] root;
  } stage_t;

endpackage
`default_nettype wire

[hdl/integer_square_root.sv]
// Top level: pipelined restoring integer square root, one radicand per cycle.
// Structure: one registered compare-subtract stage per root bit; valid_o pulses
// for one cycle per result, once the item has passed through every stage.
// Throughput: one item per cycle; busy_o is always low, results cannot be stalled.
// Reset: rst_ni clears the per-stage valid bits only; items in flight are dropped.
`default_nettype none
module integer_square_root (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [63:0] radicand_i,
  output logic        valid_o,
  output logic [31:0] root_o
);

  logic              valid [isqrt_pkg::ROOT_WIDTH+1];
  isqrt_pkg::stage_t item  [isqrt_pkg::ROOT_WIDTH+1];

  assign busy_o = 1'b0;

  assign valid[0]     = start_i & ~busy_o;
  assign item[0].rad  = isqrt_pkg::PAD_WIDTH'(radicand_i[isqrt_pkg::RADICAND_WIDTH-1:0]);
  assign item[0].rem  = '0;
  assign item[0].root = '0;

  for (genvar s = 0; s < isqrt_pkg::ROOT_WIDTH; s++) begin : g_stage
    isqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[s]),
      .item_i  (item[s]),
      .valid_o (valid[s+1]),
      .item_o  (item[s+1])
    );
  end

  assign valid_o = valid[isqrt_pkg::ROOT_WIDTH];
  assign root_o  = 32'(item[isqrt_pkg::ROOT_WIDTH].root);

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, isqrt_pkg::ROOT_WIDTH))
    else $error("integer_square_root: result without a matching start");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(radicand_i[isqrt_pkg::RADICAND_WIDTH-1:0] == '0,
                      isqrt_pkg::ROOT_WIDTH)) |-> (root_o == '0))
    else $error("integer_square_root: nonzero root for zero radicand");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("integer_square_root: busy raised");
`endif

endmodule
`default_nettype wire

[hdl/isqrt_stage.sv]
// One compare-subtract stage of the square root pipeline: settles one root bit.
`default_nettype none
module isqrt_stage (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  input  wire isqrt_pkg::stage_t item_i,
  output logic                  valid_o,
  output isqrt_pkg::stage_t     item_o
);

  logic [isqrt_pkg::EXT_WIDTH-1:0] ext;
  logic [isqrt_pkg::EXT_WIDTH-1:0] trial;
  logic [isqrt_pkg::EXT_WIDTH-1:0] diff;
  logic                            fit;
  isqrt_pkg::stage_t               item_d;
  isqrt_pkg::stage_t               item_q;
  logic                            valid_q;

  // bring down the next two radicand bits
  assign ext   = {item_i.rem, item_i.rad[isqrt_pkg::PAD_WIDTH-1 -: 2]};
  assign trial = {1'b0, item_i.root, 2'b01};
  assign diff  = ext - trial;
  assign fit   = (ext >= trial);

  always_comb begin
    item_d.rad  = item_i.rad << 2;
    item_d.rem  = fit ? diff[isqrt_pkg::REM_WIDTH-1:0] : ext[isqrt_pkg::REM_WIDTH-1:0];
    item_d.root = isqrt_pkg::ROOT_WIDTH'({item_i.root, fit});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

`ifndef SYNTHESIS
  // restoring invariant: remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (item_q.rem <= {item_q.root, 1'b0}))
    else $error("isqrt_stage: remainder above twice the partial root");

  a_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(valid_q))
    else $error("isqrt_stage: unknown valid bit");

  a_item_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !$isunknown(item_q))
    else $error("isqrt_stage: unknown item data while valid");
`endif

endmodule
`default_nettype wire

[bench/root_checker.sv]
// Checker for the integer square root block: predicts each root and compares the results in order.
module root_checker (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire                busy_i,
  input  wire         [63:0] radicand_i,
  input  wire                valid_i,
  input  wire         [31:0] root_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o
);

  localparam logic [63:0] RADICAND_MASK = {64{1'b1}} >> (64 - isqrt_pkg::RADICAND_WIDTH);

  typedef struct {
    logic [63:0] radicand;
    logic [31:0] root;
  } root_item_t;

  root_item_t  expected_roots [$];
  root_item_t  oldest;
  int unsigned mismatches = 0;
  int unsigned pending = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = pending;

  // bit-by-bit restoring square root; acc holds twice the partial root
  function automatic logic [31:0] floor_sqrt(input logic [63:0] value);
    logic [63:0] rem;
    logic [63:0] acc;
    logic [63:0] trial;
    rem = value & RADICAND_MASK;
    acc = '0;
    for (int s = isqrt_pkg::ROOT_WIDTH - 1; s >= 0; s--) begin
      trial = (acc + (64'd1 << s)) << s;
      if (rem >= trial) begin
        rem = rem - trial;
        acc = acc | (64'd2 << s);
      end
    end
    return 32'(acc >> 1);
  endfunction

  task automatic note_mismatch(input logic [63:0] radicand, input logic [31:0] want,
                               input logic [31:0] got, input bit unexpected);
    if (mismatches < 10) begin
      if (unexpected) begin
        $display("unexpected root %h with no item pending", got);
      end else begin
        $display("root mismatch: radicand %h expected %h got %h", radicand, want, got);
      end
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_roots.delete();
      pending <= 0;
    end else begin
      if (valid_i) begin
        if (expected_roots.size() == 0) begin
          note_mismatch('0, '0, root_i, 1'b1);
        end else begin
          oldest = expected_roots.pop_front();
          if (root_i !== oldest.root) begin
            note_mismatch(oldest.radicand, oldest.root, root_i, 1'b0);
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_roots.push_back('{radicand_i, floor_sqrt(radicand_i)});
      end
      pending <= expected_roots.size();
    end
  end

endmodule

[bench/integer_square_root_test.sv]
// Testbench top for the integer square root block: drives radicands and reports the verdict.
module integer_square_root_test;

  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic [63:0] radicand_i;
  logic        busy_o;
  logic        valid_o;
  logic [31:0] root_o;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count = 0;

  logic [63:0] edge_radicands [$] = '{
    64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd8, 64'd15, 64'd16, 64'd17,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
    64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000, 64'hFFFF_FFFE_0000_0002,
    64'h4000_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
    64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFE_0001
  };

  integer_square_root dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .radicand_i (radicand_i),
    .valid_o    (valid_o),
    .root_o     (root_o)
  );

  root_checker root_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .radicand_i   (radicand_i),
    .valid_i      (valid_o),
    .root_i       (root_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] random_radicand();
    logic [63:0] r;
    logic [63:0] sq;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    r = {$urandom, $urandom};
    if (kind <= 3) begin
      return r;
    end else if (kind <= 5) begin
      return r >> $urandom_range(0, 63);
    end else if (kind <= 8) begin
      // neighbors of a perfect square
      sq = 64'($urandom) * 64'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 65535));
      r = 64'($urandom);
      sq = r * r;
      return sq + 64'($urandom_range(0, 2)) - 64'd1;
    end else begin
      return {64{1'b1}} >> $urandom_range(0, 63);
    end
  endfunction

  task automatic send_radicand(input logic [63:0] value, input bit may_idle);
    int unsigned gap;
    if (may_idle && $urandom_range(0, 99) < 4) begin
      start_i <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    radicand_i <= value;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    radicand_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (edge_radicands[i]) send_radicand(edge_radicands[i], 1'b1);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_radicand(random_radicand(), !(n >= 250 && n < 400));
    end
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
